// ----- hw/rtl/lsrk_pkg.sv -----
// Shared constants, codes and types of the stack with remove by key.
package lsrk_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KEY_W   = 32;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = KEY_W + TAG_W;
  localparam int CAP_W   = 7;
  localparam int FILL_W  = 7;
  localparam int STAT_W  = 3;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_index_t;

  typedef enum logic [0:0] {
    OP_PUSH   = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [KEY_W-1:0]  key;
    logic [TAG_W-1:0]         tag;
    logic [FILL_W-1:0]        fill;
  } result_t;

endpackage

// ----- hw/rtl/lsrk_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lsrk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/lsrk_ctrl.sv -----
// Sequencer for push, top-down key search and compaction of the entry memory.
module lsrk_ctrl
  import lsrk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  op_t                     in_op,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [TAG_W-1:0]        in_tag,
  input  logic [CAP_W-1:0]        capacity,
  output mem_req_t                mem_req,
  input  logic [ENTRY_W-1:0]      rdata,
  output logic                    res_valid,
  output result_t                 res,
  input  logic                    res_ready
);

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [ADDR_W-1:0]       raddr, raddr_next;
  logic signed [KEY_W-1:0] req_key, req_key_next;
  result_t                 res_next;

  logic [CMP_W-1:0]  cap_x, depth_x, limit, cnt_x;
  logic [CNT_W-1:0]  above;
  logic              hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    raddr   <= raddr_next;
    req_key <= req_key_next;
    res     <= res_next;
  end

  always_comb begin
    cap_x   = CMP_W'(capacity);
    depth_x = CMP_W'(DEPTH);
    limit   = (cap_x < depth_x) ? cap_x : depth_x;
    cnt_x   = CMP_W'(count);
    above   = CNT_W'(raddr) + CNT_W'(1);
    hit     = (rdata[KEY_W-1:0] == req_key);

    state_next   = state;
    count_next   = count;
    raddr_next   = raddr;
    req_key_next = req_key;
    res_next     = res;
    mem_req      = '0;
    mem_req.raddr = raddr;
    in_ready     = (state == S_IDLE);
    res_valid    = (state == S_DONE);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_key_next = in_key;
          res_next.key = in_key;
          res_next.tag = '0;
          res_next.fill = FILL_W'(count);
          if (in_op == OP_PUSH) begin
            if (cnt_x >= limit) begin
              res_next.status = ST_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = ADDR_W'(count);
              mem_req.wdata = {in_tag, in_key};
              count_next    = count + CNT_W'(1);
              res_next.status = ST_PUSHED;
              res_next.tag    = in_tag;
              res_next.fill   = FILL_W'(count + CNT_W'(1));
            end
            state_next = S_DONE;
          end else if (count == '0) begin
            res_next.status = ST_EMPTY;
            state_next = S_DONE;
          end else begin
            mem_req.raddr = ADDR_W'(count - CNT_W'(1));
            raddr_next    = ADDR_W'(count - CNT_W'(1));
            state_next    = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          res_next.status = ST_REMOVED;
          res_next.key    = rdata[KEY_W-1:0];
          res_next.tag    = rdata[ENTRY_W-1:KEY_W];
          if (above < count) begin
            mem_req.raddr = raddr + ADDR_W'(1);
            raddr_next    = raddr + ADDR_W'(1);
            state_next    = S_SHIFT;
          end else begin
            count_next    = count - CNT_W'(1);
            res_next.fill = FILL_W'(count - CNT_W'(1));
            state_next    = S_DONE;
          end
        end else if (raddr == '0) begin
          res_next.status = ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          mem_req.raddr = raddr - ADDR_W'(1);
          raddr_next    = raddr - ADDR_W'(1);
        end
      end
      S_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = raddr - ADDR_W'(1);
        mem_req.wdata = rdata;
        if (above < count) begin
          mem_req.raddr = raddr + ADDR_W'(1);
          raddr_next    = raddr + ADDR_W'(1);
        end else begin
          count_next    = count - CNT_W'(1);
          res_next.fill = FILL_W'(count - CNT_W'(1));
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/lifo_stack_remove_by_key.sv -----
// Top level of the bounded stack of keyed entries with remove by key.
//
// Input items arrive on the s_axis channel: tuser carries the operation
// (push or remove by key), tdata the key and the owner tag. One result item
// per input item leaves on the m_axis channel: tuser carries the status,
// tdata the found key, the found tag and the fill count after the operation.
// The user writes the capacity register through the APB port only while the
// block is idle; the block itself does not enforce this. The effective limit
// is the smaller of the register and the memory depth. A push, a full rejection
// or a remove on an empty stack passes from acceptance through the done state
// of the sequencer into the output register. A remove walks the entry memory
// from the top down, one entry per cycle, then moves every entry above the
// match down by one, again one per cycle. The single read port of the entry
// memory sets this pace.
// The next item is accepted once the previous one has left the sequencer.
// A stalled receiver holds the result in the output register; one more
// finished result waits in the sequencer, which then stops accepting.
// Reset empties the stack, sets capacity to 64 and drops any pending result.
module lifo_stack_remove_by_key
  import lsrk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key[31:0], owner_tag[47:32]
  input  logic [0:0]            s_axis_tuser,  // op[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // found_key, found_tag, fill_count, zero
  output logic [STAT_W-1:0]     m_axis_tuser,  // status[2:0]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [CAP_W-1:0]   capacity;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rdata;
  logic               res_valid, res_ready;
  result_t            res, out_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  lsrk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (op_t'(s_axis_tuser[0])),
    .in_key    (s_axis_tdata[KEY_W-1:0]),
    .in_tag    (s_axis_tdata[ENTRY_W-1:KEY_W]),
    .capacity  (capacity),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  lsrk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {1'b0, out_res.fill, out_res.tag, out_res.key};

endmodule

// ----- hw/rtl/lsrk_checker.sv -----
// Port-level checks on the result channel of the stack, bound to the top level.
module lsrk_checker
  import lsrk_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STAT_W-1:0]     m_axis_tuser
);

  logic [FILL_W-1:0] fill;
  logic [TAG_W-1:0]  tag;

  assign fill = m_axis_tdata[ENTRY_W+FILL_W-1:ENTRY_W];
  assign tag  = m_axis_tdata[ENTRY_W-1:KEY_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("Stalled result item changed.");

  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("Result item valid right after reset.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_PUSHED) || (m_axis_tuser == ST_FULL)
      || (m_axis_tuser == ST_REMOVED) || (m_axis_tuser == ST_EMPTY)
      || (m_axis_tuser == ST_NOTFOUND))
    else $error("Result item carries an unknown status.");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (fill == '0) && (tag == '0))
    else $error("Empty status with nonzero fill or tag.");

  a_pushed_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_PUSHED) |-> (fill != '0))
    else $error("Pushed status with zero fill.");

endmodule

bind lifo_stack_remove_by_key lsrk_checker u_lsrk_checker (.*);

// ----- tb/sv/lifo_stack_remove_by_key_tb.sv -----
// Self-checking testbench for the keyed stack with remove by key.
module lifo_stack_remove_by_key_tb;
  import lsrk_pkg::*;

  typedef struct {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } stack_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // key[31:0], owner_tag[47:32]
  logic [0:0]            s_axis_tuser = '0;   // op[0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // found_key[31:0], found_tag[47:32], fill[54:48]
  logic [STAT_W-1:0]     m_axis_tuser;        // status[2:0]
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  stack_req_t pending_reqs[$];
  result_t    expected_results[$];

  logic signed [KEY_W-1:0] stk_key[DEPTH];
  logic [TAG_W-1:0]        stk_tag[DEPTH];
  int                      stk_fill = 0;
  logic [CAP_W-1:0]        cap_shadow = CAP_RESET;

  int taken_count = 0;
  int seen_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int error_count = 0;
  int result_count = 0;
  int cap_writes = 0;
  int status_hist[5] = '{default: 0};

  lifo_stack_remove_by_key DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t predict_result(op_t op, logic signed [KEY_W-1:0] key,
                                             logic [TAG_W-1:0] tag);
    result_t r;
    int      lim;
    int      pos;
    lim = (int'(cap_shadow) < DEPTH) ? int'(cap_shadow) : DEPTH;
    r.key = key;
    r.tag = '0;
    if (op == OP_PUSH) begin
      if (stk_fill >= lim) begin
        r.status = ST_FULL;
      end else begin
        stk_key[stk_fill] = key;
        stk_tag[stk_fill] = tag;
        stk_fill++;
        r.status = ST_PUSHED;
        r.tag = tag;
      end
    end else if (stk_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pos = stk_fill - 1;
      while (pos >= 0 && stk_key[pos] != key) pos--;
      if (pos < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        r.key = stk_key[pos];
        r.tag = stk_tag[pos];
        for (int j = pos; j < stk_fill - 1; j++) begin
          stk_key[j] = stk_key[j + 1];
          stk_tag[j] = stk_tag[j + 1];
        end
        stk_fill--;
        r.status = ST_REMOVED;
      end
    end
    r.fill = FILL_W'(stk_fill);
    return r;
  endfunction

  // Mostly a small pool of keys so that removes hit and duplicates occur.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return int'($urandom_range(7)) - 4;
    endcase
  endfunction

  task automatic add_req(op_t op, logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    stack_req_t r;
    r.op = op;
    r.key = key;
    r.tag = tag;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * REG_CAPACITY);
    pwdata <= {25'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cap_shadow = value;
    cap_writes++;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {25'b0, value}) begin
      $error("capacity readback: expected %0d, got %0d", value, prdata);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk) begin : drive_items
    stack_req_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || (taken_count != seen_count)) begin
      seen_count = taken_count;
      if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {req.tag, req.key};
        s_axis_tuser <= req.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin : watch_results
    result_t exp;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      taken_count++;
      expected_results.push_back(predict_result(op_t'(s_axis_tuser),
                                                s_axis_tdata[31:0], s_axis_tdata[47:32]));
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation waiting: status %0d", m_axis_tuser);
        error_count++;
      end else begin
        exp = expected_results.pop_front();
        result_count++;
        if (m_axis_tuser !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, m_axis_tuser);
          error_count++;
        end else if (exp.status <= ST_NOTFOUND) begin
          status_hist[exp.status]++;
        end
        if (m_axis_tdata[31:0] !== exp.key) begin
          $error("found_key: expected %0d, got %0d", exp.key, $signed(m_axis_tdata[31:0]));
          error_count++;
        end
        if (m_axis_tdata[47:32] !== exp.tag) begin
          $error("found_tag: expected %0d, got %0d", exp.tag, m_axis_tdata[47:32]);
          error_count++;
        end
        if (m_axis_tdata[54:48] !== exp.fill) begin
          $error("fill_count: expected %0d, got %0d", exp.fill, m_axis_tdata[54:48]);
          error_count++;
        end
      end
    end
  end

  initial begin : run_all
    int caps[14]  = '{64, 1, 64, 0, 127, 40, 80, 3, 65, 2, 64, 100, 17, 64};
    int pushp[14] = '{70, 60, 75, 50, 70, 45, 85, 50, 60, 55, 80, 35, 60, 30};
    int mode;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty stack, extreme keys and tags, duplicates, miss, middle removal.
    add_req(OP_REMOVE, 32'sd7, 16'h1234);
    add_req(OP_PUSH, 32'sh80000000, 16'h0000);
    add_req(OP_PUSH, 32'sh7fffffff, 16'hffff);
    add_req(OP_PUSH, 32'sd5, 16'h0001);
    add_req(OP_PUSH, 32'sd5, 16'h0002);
    add_req(OP_PUSH, -32'sd1, 16'haaaa);
    add_req(OP_REMOVE, 32'sd5, 16'hffff);
    add_req(OP_REMOVE, 32'sd9, 16'h0000);
    add_req(OP_REMOVE, 32'sh80000000, 16'h5555);
    add_req(OP_REMOVE, -32'sd1, 16'h0000);
    add_req(OP_REMOVE, 32'sh7fffffff, 16'h0000);
    add_req(OP_REMOVE, 32'sd5, 16'h0000);
    add_req(OP_REMOVE, 32'sd5, 16'h0000);
    wait_drained();
    write_capacity(7'd2);
    add_req(OP_PUSH, 32'sd1, 16'h00ff);
    add_req(OP_PUSH, 32'sd2, 16'hff00);
    add_req(OP_PUSH, 32'sd3, 16'h5a5a);
    wait_drained();
    // Zero capacity with entries still held: pushes fail, removes work.
    write_capacity(7'd0);
    add_req(OP_PUSH, 32'sd4, 16'h0f0f);
    add_req(OP_REMOVE, 32'sd1, 16'h0000);
    add_req(OP_REMOVE, 32'sd2, 16'h0000);
    add_req(OP_REMOVE, 32'sd2, 16'h0000);
    wait_drained();

    for (int ph = 0; ph < 14; ph++) begin
      write_capacity(CAP_W'(caps[ph]));
      mode = ph % 4;
      src_idle_pct  = (mode == 1 || mode == 3) ? ((mode == 3) ? 25 : 62) : 0;
      snk_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 25 : 62) : 0;
      for (int n = 0; n < 125; n++) begin
        add_req(($urandom_range(99) < pushp[ph]) ? OP_PUSH : OP_REMOVE, pick_key(),
                16'($urandom()));
      end
      wait_drained();
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (80) @(negedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected result items never arrived", expected_results.size());
      error_count++;
    end
    $display("Checked %0d result items across %0d capacity writes.", result_count, cap_writes);
    $display("Pushed %0d, full %0d, removed %0d, empty %0d, not found %0d.",
             status_hist[ST_PUSHED], status_hist[ST_FULL], status_hist[ST_REMOVED],
             status_hist[ST_EMPTY], status_hist[ST_NOTFOUND]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lsrk_pkg.sv
hw/rtl/lsrk_ram.sv
hw/rtl/lsrk_ctrl.sv
hw/rtl/lifo_stack_remove_by_key.sv
hw/rtl/lsrk_checker.sv
tb/sv/lifo_stack_remove_by_key_tb.sv
